/* hdl/battery_charge_percent_gauge_unit_defines.svh */
// assertion macros used by the checker file
`ifndef BATTERY_CHARGE_PERCENT_GAUGE_UNIT_DEFINES_SVH
`define BATTERY_CHARGE_PERCENT_GAUGE_UNIT_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define BCPG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while reset is high
`define BCPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/bcpg_pkg.sv */
package bcpg_pkg;

   localparam int READ_W  = 12;
   localparam int OFF_W   = 10;
   localparam int MV_W    = 14;
   localparam int PCT_W   = 7;

   localparam int TABLE_POINTS = 9;
   localparam int SEG_CNT      = TABLE_POINTS - 1;
   localparam int SEG_W        = $clog2(SEG_CNT);
   localparam int PT_IDX_W     = $clog2(TABLE_POINTS);

   // widest segment is 300 mV wide
   localparam int DELTA_W     = 9;
   localparam int SLOPE_W     = 18;
   localparam int SLOPE_SHIFT = 20;
   localparam int PROD_W      = DELTA_W + SLOPE_W;

   localparam logic [OFF_W-1:0] OFFSET_RESET_MV = 10'd485;
   localparam logic [PCT_W-1:0] PCT_FULL        = 7'd100;

   localparam logic [MV_W-1:0] VOLT_MV [TABLE_POINTS] = '{
      14'd3000, 14'd3300, 14'd3500, 14'd3650, 14'd3750,
      14'd3850, 14'd3970, 14'd4030, 14'd4100
   };

   localparam logic [PCT_W-1:0] PCT_TABLE [TABLE_POINTS] = '{
      7'd0, 7'd5, 7'd20, 7'd40, 7'd55, 7'd70, 7'd85, 7'd93, 7'd100
   };

   // ceil(rise * 2^20 / span) per segment, exact floor for any delta inside the span
   localparam logic [SLOPE_W-1:0] SEG_SLOPE [SEG_CNT] = '{
      18'd17477, 18'd78644, 18'd139811, 18'd157287,
      18'd157287, 18'd131072, 18'd139811, 18'd104858
   };

   typedef struct packed {
      logic [READ_W-1:0] reading_mv;
      logic              read_ok;
      logic              charger_connected;
   } req_type;

   typedef struct packed {
      logic [MV_W-1:0]  raw_battery_mv;
      logic [MV_W-1:0]  adjusted_battery_mv;
      logic [PCT_W-1:0] charge_percent;
   } rsp_type;

   typedef struct packed {
      logic [MV_W-1:0]    raw_mv;
      logic [MV_W-1:0]    adj_mv;
      logic               below;
      logic               above;
      logic [SEG_W-1:0]   seg;
      logic [DELTA_W-1:0] delta;
   } volt_type;

endpackage

/* hdl/bcpg_volt.sv */
module bcpg_volt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  bcpg_pkg::req_type          in_data,
   input  logic [bcpg_pkg::OFF_W-1:0] offset_mv,
   output logic                       out_valid,
   input  logic                       out_ready,
   output bcpg_pkg::volt_type         out_data
);

   logic              valid_ff, valid_in;
   bcpg_pkg::req_type data_ff;

   logic [bcpg_pkg::MV_W-1:0]  raw_mv;
   logic [bcpg_pkg::MV_W-1:0]  adj_mv;
   logic [bcpg_pkg::MV_W-1:0]  off_ext;
   logic [bcpg_pkg::SEG_W-1:0] seg;
   logic [bcpg_pkg::MV_W-1:0]  base_mv;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   always_comb begin
      off_ext = bcpg_pkg::MV_W'(offset_mv);
      // times three as x + 2x
      raw_mv  = data_ff.read_ok ?
                (bcpg_pkg::MV_W'(data_ff.reading_mv) + {1'b0, data_ff.reading_mv, 1'b0}) :
                '0;
      adj_mv  = raw_mv;
      if (data_ff.charger_connected) begin
         adj_mv = (raw_mv > off_ext) ? (raw_mv - off_ext) : '0;
      end
      seg = '0;
      for (int i = 1; i < bcpg_pkg::TABLE_POINTS - 1; i++) begin
         if (adj_mv >= bcpg_pkg::VOLT_MV[i]) begin
            seg = bcpg_pkg::SEG_W'(i);
         end
      end
      base_mv = bcpg_pkg::VOLT_MV[bcpg_pkg::PT_IDX_W'(seg)];
   end

   assign out_valid      = valid_ff;
   assign out_data.raw_mv = raw_mv;
   assign out_data.adj_mv = adj_mv;
   assign out_data.below  = (adj_mv <= bcpg_pkg::VOLT_MV[0]);
   assign out_data.above  = (adj_mv >= bcpg_pkg::VOLT_MV[bcpg_pkg::TABLE_POINTS-1]);
   assign out_data.seg    = seg;
   // only meaningful inside the table range, masked downstream otherwise
   assign out_data.delta  = bcpg_pkg::DELTA_W'(adj_mv - base_mv);

endmodule

/* hdl/bcpg_interp.sv */
module bcpg_interp (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bcpg_pkg::volt_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output bcpg_pkg::rsp_type  out_data
);

   logic               mid_valid_ff, mid_valid_in;
   bcpg_pkg::volt_type mid_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   bcpg_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_open;

   logic [bcpg_pkg::PROD_W-1:0] prod;
   logic [bcpg_pkg::PCT_W-1:0]  step;
   logic [bcpg_pkg::PCT_W-1:0]  seg_pct;

   assign rsp_open     = !rsp_valid_ff || out_ready;
   assign in_ready     = !mid_valid_ff || rsp_open;
   assign mid_valid_in = in_ready ? in_valid : mid_valid_ff;
   assign rsp_valid_in = rsp_open ? mid_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mid_ff <= in_data;
      end
      if (mid_valid_ff && rsp_open) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      prod    = bcpg_pkg::PROD_W'(mid_ff.delta) *
                bcpg_pkg::PROD_W'(bcpg_pkg::SEG_SLOPE[mid_ff.seg]);
      step    = prod[bcpg_pkg::SLOPE_SHIFT +: bcpg_pkg::PCT_W];
      seg_pct = bcpg_pkg::PCT_TABLE[bcpg_pkg::PT_IDX_W'(mid_ff.seg)] + step;
      rsp_in.raw_battery_mv      = mid_ff.raw_mv;
      rsp_in.adjusted_battery_mv = mid_ff.adj_mv;
      if (mid_ff.below) begin
         rsp_in.charge_percent = '0;
      end else if (mid_ff.above) begin
         rsp_in.charge_percent = bcpg_pkg::PCT_FULL;
      end else begin
         rsp_in.charge_percent = seg_pct;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

/* hdl/battery_charge_percent_gauge_unit.sv */
// battery state-of-charge gauge
// req channel: one transaction per ADC sample (reading_mv, read_ok, charger_connected);
// rsp channel: one transaction per request with raw mV, offset-adjusted mV and percent.
// csr port: csr_write_en with csr_write_data loads the 10-bit charger offset in mV;
// write it only while no transaction is in flight.
// three register stages: input, voltage and segment, result; a request passes
// them in that order and rsp offers it from the result stage.
// throughput: one transaction per cycle while rsp_ready is high; the slope multiply
// sits in the last stage.
// a stalled rsp_ready holds the result in place; the stages behind it keep filling
// and req_ready drops only when all three hold a transaction.
// reset (synchronous) empties the pipeline and sets the offset to 485 mV.
module battery_charge_percent_gauge_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [bcpg_pkg::OFF_W-1:0] csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  bcpg_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output bcpg_pkg::rsp_type          rsp_data
);

   logic [bcpg_pkg::OFF_W-1:0] offset_ff;
   logic                       volt_valid;
   logic                       volt_ready;
   bcpg_pkg::volt_type         volt_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= bcpg_pkg::OFFSET_RESET_MV;
      end else if (csr_write_en) begin
         offset_ff <= csr_write_data;
      end
   end

   bcpg_volt u_volt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .offset_mv (offset_ff),
      .out_valid (volt_valid),
      .out_ready (volt_ready),
      .out_data  (volt_data)
   );

   bcpg_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (volt_valid),
      .in_ready  (volt_ready),
      .in_data   (volt_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

/* hdl/bcpg_checker.sv */
`include "battery_charge_percent_gauge_unit_defines.svh"

module bcpg_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bcpg_pkg::rsp_type rsp_data
);

   // a stalled transaction stays put
   `BCPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp changed while stalled")

   // the offset only ever lowers the voltage
   `BCPG_ASSERT_IMPLY(a_adj_le_raw, clock, reset, rsp_valid, rsp_data.adjusted_battery_mv <= rsp_data.raw_battery_mv, "adjusted above raw")

   `BCPG_ASSERT_IMPLY(a_pct_range, clock, reset, rsp_valid, rsp_data.charge_percent <= 7'd100, "percent above 100")

   // a dead reading sits below the table
   `BCPG_ASSERT_IMPLY(a_zero_empty, clock, reset, rsp_valid && rsp_data.raw_battery_mv == '0, rsp_data.charge_percent == '0, "nonzero percent at zero volts")

endmodule

bind battery_charge_percent_gauge_unit bcpg_checker u_bcpg_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
   import bcpg_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en = 1'b0;
   logic [OFF_W-1:0]  csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;

   // model copy of the charger offset register
   logic [OFF_W-1:0]  gauge_offset_mv = OFFSET_RESET_MV;
   rsp_type           expected_gauge_q[$];

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned rsp_hold_cycles = 0;

   int unsigned n_sent = 0;
   int unsigned n_checked = 0;
   int unsigned n_read_err = 0;
   int unsigned n_clamped = 0;
   int unsigned n_empty = 0;
   int unsigned n_full = 0;
   int unsigned n_errors = 0;

   battery_charge_percent_gauge_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

   always #6 clock = ~clock;

   function automatic rsp_type gauge_predict(req_type item, logic [OFF_W-1:0] offset_mv);
      rsp_type     r;
      int unsigned raw_mv;
      int unsigned adj_mv;
      int unsigned pct;
      int unsigned v0;
      int unsigned v1;
      int unsigned p0;
      int unsigned p1;
      raw_mv = item.read_ok ? int'(item.reading_mv) * 3 : 0;
      adj_mv = raw_mv;
      if (item.charger_connected)
         adj_mv = (raw_mv > offset_mv) ? raw_mv - offset_mv : 0;
      pct = 100;
      if (adj_mv <= VOLT_MV[0]) begin
         pct = 0;
      end else if (adj_mv < VOLT_MV[TABLE_POINTS-1]) begin
         for (int i = 0; i < TABLE_POINTS - 1; i++) begin
            v0 = 32'(VOLT_MV[i]);
            v1 = 32'(VOLT_MV[i+1]);
            p0 = 32'(PCT_TABLE[i]);
            p1 = 32'(PCT_TABLE[i+1]);
            if (adj_mv >= v0 && adj_mv < v1)
               pct = p0 + ((adj_mv - v0) * (p1 - p0)) / (v1 - v0);
         end
      end
      r.raw_battery_mv      = raw_mv[MV_W-1:0];
      r.adjusted_battery_mv = adj_mv[MV_W-1:0];
      r.charge_percent      = pct[PCT_W-1:0];
      return r;
   endfunction

   // offers one sample and waits for the transaction; valid stays up save in an idle gap
   task automatic send_sample(req_type item);
      rsp_type exp_rsp;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      exp_rsp = gauge_predict(item, gauge_offset_mv);
      expected_gauge_q.push_back(exp_rsp);
      n_sent++;
      if (!item.read_ok)
         n_read_err++;
      if (exp_rsp.raw_battery_mv != 0 && exp_rsp.adjusted_battery_mv == 0)
         n_clamped++;
      if (exp_rsp.charge_percent == 0)
         n_empty++;
      if (exp_rsp.charge_percent == PCT_FULL)
         n_full++;
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (expected_gauge_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_charge_offset(logic [OFF_W-1:0] value);
      req_valid <= 1'b0;
      wait_drained();
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en    <= 1'b0;
      gauge_offset_mv = value;
   endtask

   function automatic req_type random_sample();
      req_type item;
      // most readings land near the table range, with or without the offset
      if ($urandom_range(0, 3) == 0)
         item.reading_mv = 12'($urandom_range(0, 4095));
      else
         item.reading_mv = 12'($urandom_range(900, 1750));
      item.read_ok           = ($urandom_range(0, 9) != 0);
      item.charger_connected = 1'($urandom_range(0, 1));
      return item;
   endfunction

   // reset value of the offset plus field extremes and saturation cases
   task automatic test_reset_defaults();
      send_sample('{reading_mv: 12'd0,    read_ok: 1'b1, charger_connected: 1'b0});
      send_sample('{reading_mv: 12'd4095, read_ok: 1'b1, charger_connected: 1'b0});
      send_sample('{reading_mv: 12'd4095, read_ok: 1'b0, charger_connected: 1'b1});
      send_sample('{reading_mv: 12'd4095, read_ok: 1'b1, charger_connected: 1'b1});
      send_sample('{reading_mv: 12'd100,  read_ok: 1'b1, charger_connected: 1'b1});
      send_sample('{reading_mv: 12'd1000, read_ok: 1'b1, charger_connected: 1'b0});
      send_sample('{reading_mv: 12'd1367, read_ok: 1'b1, charger_connected: 1'b0});
      send_sample('{reading_mv: 12'd1200, read_ok: 1'b1, charger_connected: 1'b1});
   endtask

   // hit every table voltage exactly; small offsets fill in the non-multiples of three
   task automatic test_table_breakpoints();
      int unsigned v;
      req_type     item;
      write_charge_offset(10'd1);
      for (int i = 0; i < TABLE_POINTS; i++) begin
         v = 32'(VOLT_MV[i]);
         item.read_ok = 1'b1;
         if (v % 3 == 0) begin
            item.reading_mv        = 12'(v / 3);
            item.charger_connected = 1'b0;
            send_sample(item);
         end else if (v % 3 == 2) begin
            item.reading_mv        = 12'((v + 1) / 3);
            item.charger_connected = 1'b1;
            send_sample(item);
         end
      end
      write_charge_offset(10'd2);
      for (int i = 0; i < TABLE_POINTS; i++) begin
         v = 32'(VOLT_MV[i]);
         if (v % 3 == 1) begin
            item.reading_mv        = 12'((v + 2) / 3);
            item.read_ok           = 1'b1;
            item.charger_connected = 1'b1;
            send_sample(item);
         end
      end
   endtask

   task automatic test_random_traffic(int unsigned src_idle, int unsigned dst_idle,
                                      logic [OFF_W-1:0] first_offset);
      req_idle_pct = src_idle;
      rsp_idle_pct = dst_idle;
      for (int chunk = 0; chunk < 3; chunk++) begin
         write_charge_offset(chunk == 0 ? first_offset : OFF_W'($urandom_range(0, 1023)));
         for (int n = 0; n < 90; n++)
            send_sample(random_sample());
      end
   endtask

   // receiver stops long enough for the pipeline to fill and push back on requests
   task automatic test_output_stall();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_charge_offset(OFFSET_RESET_MV);
      rsp_hold_cycles = 60;
      for (int n = 0; n < 40; n++)
         send_sample(random_sample());
      req_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (rsp_hold_cycles != 0) begin
         rsp_hold_cycles = rsp_hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_gauge_q.size() == 0) begin
            $display("%0t: unexpected transaction %p", $time, rsp_data);
            n_errors++;
         end else begin
            exp_rsp = expected_gauge_q.pop_front();
            n_checked++;
            if (rsp_data.raw_battery_mv != exp_rsp.raw_battery_mv) begin
               $display("%0t: raw_battery_mv expected %0d actual %0d", $time,
                        exp_rsp.raw_battery_mv, rsp_data.raw_battery_mv);
               n_errors++;
            end
            if (rsp_data.adjusted_battery_mv != exp_rsp.adjusted_battery_mv) begin
               $display("%0t: adjusted_battery_mv expected %0d actual %0d", $time,
                        exp_rsp.adjusted_battery_mv, rsp_data.adjusted_battery_mv);
               n_errors++;
            end
            if (rsp_data.charge_percent != exp_rsp.charge_percent) begin
               $display("%0t: charge_percent expected %0d actual %0d", $time,
                        exp_rsp.charge_percent, rsp_data.charge_percent);
               n_errors++;
            end
         end
      end
   end

   initial begin
      int unsigned drain_cycles;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_table_breakpoints();
      test_random_traffic(21, 62, 10'd0);
      test_random_traffic(62, 21, 10'd1023);
      test_random_traffic(0, 0, OFFSET_RESET_MV);
      test_output_stall();
      drain_cycles = 0;
      while (expected_gauge_q.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (expected_gauge_q.size() != 0) begin
         $display("%0t: %0d expected transactions never arrived", $time,
                  expected_gauge_q.size());
         n_errors += expected_gauge_q.size();
      end
      $display("covered %0d samples, %0d results checked: %0d read errors, %0d clamped to 0 mV",
               n_sent, n_checked, n_read_err, n_clamped);
      $display("charge at 0%%: %0d, at 100%%: %0d, offsets 0, 1, 2, 485, 1023 and random",
               n_empty, n_full);
      if (n_errors == 0)
         $display("battery_charge_percent_gauge_unit regression: pass");
      else
         $display("battery_charge_percent_gauge_unit regression: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout at %0t", $time);
      $display("battery_charge_percent_gauge_unit regression: fail");
      $finish;
   end

endmodule
